@@ rtl/cpsp_pkg.sv @@
package cpsp_pkg;

  localparam int AMP_W    = 16;
  localparam int AMP_FRAC = 12;
  localparam int PAN_W    = 18;
  // clamped pan 0..1.0 needs one bit above the Q16 fraction
  localparam int PAN_VW   = 17;
  localparam int PAN_FRAC = 16;
  localparam logic [PAN_VW-1:0] PAN_ONE = 17'h10000;

  localparam int PERIOD_W = 16;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd44;

  // sequencing strobes from the control FSM to each channel
  typedef struct packed {
    logic gain_lin;
    logic sqrt_start;
    logic sqrt_step;
    logic gain_sqrt;
    logic kmul_start;
    logic kmul_step;
    logic smul_start;
    logic smul_step;
  } cpsp_ctrl_t;

endpackage

@@ rtl/cpsp_in_if.sv @@
interface cpsp_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                                valid;
  logic                                ready;
  logic signed [SAMPLE_WIDTH-1:0]      sample;
  logic        [cpsp_pkg::AMP_W-1:0]   amplitude;
  logic signed [cpsp_pkg::PAN_W-1:0]   pan_pos;
  logic                                linear_mode;

  modport source (output valid, output sample, output amplitude, output pan_pos,
                  output linear_mode, input ready);
  modport sink   (input valid, input sample, input amplitude, input pan_pos,
                  input linear_mode, output ready);
endinterface

@@ rtl/cpsp_out_if.sv @@
interface cpsp_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ rtl/cpsp_cfg_if.sv @@
interface cpsp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cpsp_pkg::PERIOD_W-1:0]   update_period;

  modport source (output valid, output update_period, input ready);
  modport sink   (input valid, input update_period, output ready);
endinterface

@@ rtl/cpsp_isqrt.sv @@
module cpsp_isqrt #(
  parameter int ROOT_W = 17
) (
  input  logic                  clk,
  input  logic                  start,
  input  logic                  step,
  input  logic [2*ROOT_W-1:0]   x,
  output logic [ROOT_W-1:0]     root
);
  // restoring square root, one root bit (two radicand bits) per step

  logic [2*ROOT_W-1:0] xs;
  logic [ROOT_W+1:0]   rem;
  logic [ROOT_W+3:0]   cur;
  logic [ROOT_W+3:0]   trial;
  logic [ROOT_W+3:0]   diff;
  logic                fits;

  assign cur   = {rem, xs[2*ROOT_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign diff  = cur - trial;
  assign fits  = (cur >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
    end else if (step) begin
      xs   <= {xs[2*ROOT_W-3:0], 2'b00};
      rem  <= fits ? diff[ROOT_W+1:0] : cur[ROOT_W+1:0];
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

@@ rtl/cpsp_chan.sv @@
module cpsp_chan #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  cpsp_pkg::cpsp_ctrl_t           ctrl,
  input  logic [cpsp_pkg::PAN_VW-1:0]    pan,
  input  logic [cpsp_pkg::AMP_W-1:0]     amp,
  input  logic [SAMPLE_WIDTH-1:0]        mag,
  input  logic                           neg,
  output logic [SAMPLE_WIDTH-1:0]        res
);
  import cpsp_pkg::*;

  localparam int G  = GAIN_FRAC_BITS;
  localparam int SW = SAMPLE_WIDTH;
  localparam int GW = G + 1;
  localparam int KW = AMP_W + GW;
  localparam int QW = KW + SW;
  localparam int SH = AMP_FRAC + G;
  localparam int RW = QW - SH;
  localparam int XW = 2 * GW;
  localparam logic [RW:0] LIM   = {{(RW+1-SW){1'b0}}, 1'b1, {(SW-1){1'b0}}};
  localparam logic [RW:0] LIM_P = LIM - {{RW{1'b0}}, 1'b1};

  logic [PAN_VW+G-1:0] lin_wide;
  logic [GW-1:0]       lin_gain;
  logic [XW-1:0]       sq_in;
  logic [GW-1:0]       root;
  logic [GW-1:0]       gain;
  logic [GW-1:0]       gain_next;
  logic [KW-1:0]       kp;
  logic [AMP_W:0]      ksum;
  logic [QW-1:0]       acc;
  logic [KW:0]         qsum;
  logic [RW:0]         rnd;
  logic [RW:0]         sat_p;
  logic [RW:0]         sat_n;
  logic [SW-1:0]       mag_n;

  assign lin_wide = {{G{1'b0}}, pan} << G;
  assign lin_gain = lin_wide[PAN_VW+G-1:PAN_FRAC];
  assign sq_in    = {{(XW-PAN_VW){1'b0}}, pan} << (2*G - PAN_FRAC);

  cpsp_isqrt #(.ROOT_W(GW)) u_sqrt (
    .clk   (clk),
    .start (ctrl.sqrt_start),
    .step  (ctrl.sqrt_step),
    .x     (sq_in),
    .root  (root)
  );

  always_comb begin
    gain_next = gain;
    if (ctrl.gain_lin) begin
      gain_next = lin_gain;
    end else if (ctrl.gain_sqrt) begin
      gain_next = root;
    end
  end

  // kp: amp * gain, shift-add over the gain bits held in its low end
  assign ksum = {1'b0, kp[KW-1:GW]} + (kp[0] ? {1'b0, amp} : '0);
  // acc: |sample| * kp, shift-add over the sample bits
  assign qsum = {1'b0, acc[QW-1:SW]} + (acc[0] ? {1'b0, kp} : '0);

  always_ff @(posedge clk) begin
    gain <= gain_next;
    if (ctrl.kmul_start) begin
      kp <= {{AMP_W{1'b0}}, gain_next};
    end else if (ctrl.kmul_step) begin
      kp <= {ksum, kp[GW-1:1]};
    end
    if (ctrl.smul_start) begin
      acc <= {{KW{1'b0}}, mag};
    end else if (ctrl.smul_step) begin
      acc <= {qsum, acc[SW-1:1]};
    end
  end

  // round magnitude half away from zero, then saturate by sign
  assign rnd   = {1'b0, acc[QW-1:SH]} + {{RW{1'b0}}, acc[SH-1]};
  assign sat_p = (rnd > LIM_P) ? LIM_P : rnd;
  assign sat_n = (rnd > LIM) ? LIM : rnd;
  assign mag_n = sat_n[SW-1:0];
  assign res   = neg ? (~mag_n + {{(SW-1){1'b0}}, 1'b1}) : sat_p[SW-1:0];

endmodule

@@ rtl/constant_power_stereo_panner.sv @@
// Mono-to-stereo panner with constant-power or linear pan law.
// in_ch  : valid/ready transfer of one sample with amplitude (Q4.12),
//          pan position (Q16, clamped to 0..1.0) and a linear-mode flag.
// out_ch : valid/ready transfer of the left/right pair, saturated.
// cfg    : always ready; a transfer writes update_period (reset 44). Write it
//          only while no sample is in flight.
// Control inputs are taken on the first sample and then every update_period
// samples; gains are recomputed only when the clamped pan has moved.
// One sample at a time. The |sample| x (amp*gain) product is bit-serial, one
// sample bit per cycle. An update first runs the serial amp*gain product; a
// new constant-power pan runs the bit-pair serial square root before that.
// A finished pair sits in the output register; the next sample is accepted
// meanwhile, and the block holds its following result until out_ch drains.
// Reset (synchronous) empties the output and forces an update on the next
// sample.
module constant_power_stereo_panner #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  cpsp_in_if.sink       in_ch,
  cpsp_out_if.source    out_ch,
  cpsp_cfg_if.sink      cfg
);
  import cpsp_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int STEPS = (GAIN_FRAC_BITS + 1 > SW) ? GAIN_FRAC_BITS + 1 : SW;
  localparam int CNT_W = $clog2(STEPS);
  localparam logic [CNT_W-1:0] G_LAST = CNT_W'(GAIN_FRAC_BITS);
  localparam logic [CNT_W-1:0] S_LAST = CNT_W'(SW - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQRT  = 3'd1;
  localparam logic [2:0] S_SQFIN = 3'd2;
  localparam logic [2:0] S_KMUL  = 3'd3;
  localparam logic [2:0] S_SMUL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]          state;
  logic [CNT_W-1:0]    cnt;
  logic [PERIOD_W-1:0] update_period;
  logic [PERIOD_W-1:0] countdown;
  logic                prev_ok;
  logic [PAN_VW-1:0]   prev_pan;
  logic [AMP_W-1:0]    held_amp;
  logic                neg;
  logic                out_valid;

  logic                accept;
  logic                upd;
  logic                pan_new;
  logic                out_free;
  logic [PAN_VW-1:0]   pan_clamp;
  logic [PAN_VW-1:0]   pan_right;
  logic [SW-1:0]       mag;
  logic [SW-1:0]       res_l;
  logic [SW-1:0]       res_r;
  cpsp_ctrl_t          ctrl;

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign out_ch.valid = out_valid;

  assign accept   = in_ch.valid && in_ch.ready;
  assign upd      = (countdown <= {{(PERIOD_W-1){1'b0}}, 1'b1});
  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    if (in_ch.pan_pos[PAN_W-1]) begin
      pan_clamp = '0;
    end else if (in_ch.pan_pos[PAN_VW-1:0] > PAN_ONE) begin
      pan_clamp = PAN_ONE;
    end else begin
      pan_clamp = in_ch.pan_pos[PAN_VW-1:0];
    end
  end

  assign pan_right = PAN_ONE - pan_clamp;
  assign pan_new   = !prev_ok || (pan_clamp != prev_pan);
  assign mag       = in_ch.sample[SW-1] ? (~in_ch.sample + {{(SW-1){1'b0}}, 1'b1})
                                        : in_ch.sample;

  always_comb begin
    ctrl = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ctrl.smul_start = 1'b1;
          if (upd) begin
            if (pan_new && !in_ch.linear_mode) begin
              ctrl.sqrt_start = 1'b1;
            end else begin
              ctrl.gain_lin   = pan_new;
              ctrl.kmul_start = 1'b1;
            end
          end
        end
      end
      S_SQRT: begin
        ctrl.sqrt_step = 1'b1;
      end
      S_SQFIN: begin
        ctrl.gain_sqrt  = 1'b1;
        ctrl.kmul_start = 1'b1;
      end
      S_KMUL: begin
        ctrl.kmul_step = 1'b1;
      end
      S_SMUL: begin
        ctrl.smul_step = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

  cpsp_chan #(.SAMPLE_WIDTH(SW), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_left (
    .clk  (clk),
    .ctrl (ctrl),
    .pan  (pan_clamp),
    .amp  (held_amp),
    .mag  (mag),
    .neg  (neg),
    .res  (res_l)
  );

  cpsp_chan #(.SAMPLE_WIDTH(SW), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_right (
    .clk  (clk),
    .ctrl (ctrl),
    .pan  (pan_right),
    .amp  (held_amp),
    .mag  (mag),
    .neg  (neg),
    .res  (res_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      update_period <= PERIOD_RESET;
      countdown     <= '0;
      prev_ok       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        update_period <= cfg.update_period;
      end

      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            countdown <= upd ? update_period : countdown - {{(PERIOD_W-1){1'b0}}, 1'b1};
            if (upd) begin
              prev_ok <= 1'b1;
              state   <= (pan_new && !in_ch.linear_mode) ? S_SQRT : S_KMUL;
            end else begin
              state <= S_SMUL;
            end
          end
        end
        S_SQRT: begin
          if (cnt == G_LAST) begin
            cnt   <= '0;
            state <= S_SQFIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SQFIN: begin
          state <= S_KMUL;
        end
        S_KMUL: begin
          if (cnt == G_LAST) begin
            cnt   <= '0;
            state <= S_SMUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_SMUL: begin
          if (cnt == S_LAST) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= in_ch.sample[SW-1];
      if (upd) begin
        held_amp <= in_ch.amplitude;
        prev_pan <= pan_clamp;
      end
    end
    if (state == S_DONE && out_free) begin
      out_ch.left_out  <= res_l;
      out_ch.right_out <= res_r;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ch.ready)
    else $error("input ready while a sample is in flight");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == S_DONE)
    else $error("output became valid without a finished sample");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_ch.valid && !out_ch.ready) |=> state == S_DONE)
    else $error("finished result dropped while output stalled");
`endif

endmodule
